[hw/rtl/hanzi_pinyin_keyword_matcher_assert.svh]
// Assertion macros for the pinyin keyword matcher checker.
`ifndef HANZI_PINYIN_KEYWORD_MATCHER_ASSERT_SVH
`define HANZI_PINYIN_KEYWORD_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HPKM_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define HPKM_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) else $error(msg);

`endif

[hw/rtl/hpkm_pkg.sv]
// Package: types, constants and the hanzi-to-pinyin ROM of the keyword matcher.
package hpkm_pkg;

  localparam int SylBytes      = 6;
  localparam int MaxPush       = SylBytes + 1;
  localparam int MaxKeywordDef = 32;
  localparam int KwRegs        = 4;
  localparam int KwBytes       = 8 * KwRegs;
  localparam int KlenW         = 6;
  localparam int CfgDataW      = 64;
  localparam int CfgIdxW       = 3;
  localparam int SylLenW       = $clog2(SylBytes + 1);
  localparam int PushW         = $clog2(MaxPush + 1);
  localparam logic [7:0] SpaceChar = 8'h20;

  typedef logic [7:0] byte_t;
  typedef logic [8*SylBytes-1:0] syl_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeywordLength = 3'd0,
    RegKeyword0      = 3'd1,
    RegKeyword1      = 3'd2,
    RegKeyword2      = 3'd3,
    RegKeyword3      = 3'd4
  } cfg_reg_e;

  // Syllable right-aligned, first letter in the highest nonzero byte; zero on miss.
  function automatic syl_t rom_syl(logic [15:0] cp);
    syl_t s;
    s = '0;
    case (cp)
      16'h4F60: s = "ni";     16'h597D: s = "hao";    16'h5C0F: s = "xiao";
      16'h5343: s = "qian";   16'h7AD9: s = "zhan";   16'h8D77: s = "qi";
      16'h6765: s = "lai";    16'h8BF4: s = "shuo";   16'h8BDD: s = "hua";
      16'h6253: s = "da";     16'h5F00: s = "kai";    16'h5173: s = "guan";
      16'h505C: s = "ting";   16'h8D70: s = "zou";    16'h8DD1: s = "pao";
      16'h524D: s = "qian";   16'h540E: s = "hou";    16'h5DE6: s = "zuo";
      16'h53F3: s = "you";    16'h4E0A: s = "shang";  16'h4E0B: s = "xia";
      16'h56DE: s = "hui";    16'h53BB: s = "qu";     16'h8F6C: s = "zhuan";
      16'h662F: s = "shi";    16'h6709: s = "you";    16'h4E0D: s = "bu";
      16'h5728: s = "zai";    16'h4E86: s = "le";     16'h4F1A: s = "hui";
      16'h80FD: s = "neng";   16'h8981: s = "yao";    16'h60F3: s = "xiang";
      16'h770B: s = "kan";    16'h542C: s = "ting";   16'h5403: s = "chi";
      16'h559D: s = "he";     16'h505A: s = "zuo";    16'h8BA9: s = "rang";
      16'h7ED9: s = "gei";    16'h62FF: s = "na";     16'h653E: s = "fang";
      16'h7B49: s = "deng";   16'h5E26: s = "dai";    16'h95EE: s = "wen";
      16'h7B54: s = "da";     16'h544A: s = "gao";    16'h8BC9: s = "su";
      16'h77E5: s = "zhi";    16'h9053: s = "dao";    16'h660E: s = "ming";
      16'h767D: s = "bai";    16'h61C2: s = "dong";   16'h8BB0: s = "ji";
      16'h6211: s = "wo";     16'h4ED6: s = "ta";     16'h5979: s = "ta";
      16'h5B83: s = "ta";     16'h4EEC: s = "men";    16'h8FD9: s = "zhe";
      16'h90A3: s = "na";     16'h54EA: s = "na";     16'h4EC0: s = "shen";
      16'h4E48: s = "me";     16'h8C01: s = "shui";   16'h4EBA: s = "ren";
      16'h5BB6: s = "jia";    16'h670B: s = "peng";   16'h53CB: s = "you";
      16'h673A: s = "ji";     16'h5668: s = "qi";     16'h5929: s = "tian";
      16'h5730: s = "di";     16'h6C34: s = "shui";   16'h706B: s = "huo";
      16'h98CE: s = "feng";   16'h96E8: s = "yu";     16'h4E91: s = "yun";
      16'h82B1: s = "hua";    16'h4E66: s = "shu";    16'h7535: s = "dian";
      16'h95E8: s = "men";    16'h7A97: s = "chuang"; 16'h8F66: s = "che";
      16'h623F: s = "fang";   16'h684C: s = "zhuo";   16'h6905: s = "yi";
      16'h996D: s = "fan";    16'h83DC: s = "cai";    16'h8336: s = "cha";
      16'h9152: s = "jiu";    16'h624B: s = "shou";   16'h811A: s = "jiao";
      16'h5934: s = "tou";    16'h773C: s = "yan";    16'h8033: s = "er";
      16'h53E3: s = "kou";    16'h9F3B: s = "bi";     16'h5FC3: s = "xin";
      16'h5927: s = "da";     16'h591A: s = "duo";    16'h5C11: s = "shao";
      16'h9AD8: s = "gao";    16'h4F4E: s = "di";     16'h957F: s = "chang";
      16'h77ED: s = "duan";   16'h5FEB: s = "kuai";   16'h6162: s = "man";
      16'h65B0: s = "xin";    16'h65E7: s = "jiu";    16'h574F: s = "huai";
      16'h5BF9: s = "dui";    16'h9519: s = "cuo";    16'h771F: s = "zhen";
      16'h5047: s = "jia";    16'h70ED: s = "re";     16'h51B7: s = "leng";
      16'h5E72: s = "gan";    16'h6E7F: s = "shi";    16'h4EAE: s = "liang";
      16'h6697: s = "an";     16'h8F7B: s = "qing";   16'h91CD: s = "zhong";
      16'h8FDC: s = "yuan";   16'h8FD1: s = "jin";    16'h6DF1: s = "shen";
      16'h6D45: s = "qian";   16'h5F88: s = "hen";    16'h592A: s = "tai";
      16'h6700: s = "zui";    16'h66F4: s = "geng";   16'h975E: s = "fei";
      16'h5E38: s = "chang";  16'h90FD: s = "dou";    16'h4E5F: s = "ye";
      16'h8FD8: s = "hai";    16'h5C31: s = "jiu";    16'h4E00: s = "yi";
      16'h4E8C: s = "er";     16'h4E09: s = "san";    16'h56DB: s = "si";
      16'h4E94: s = "wu";     16'h516D: s = "liu";    16'h4E03: s = "qi";
      16'h516B: s = "ba";     16'h4E5D: s = "jiu";    16'h5341: s = "shi";
      16'h767E: s = "bai";    16'h4E07: s = "wan";    16'h4EBF: s = "yi";
      16'h96F6: s = "ling";   16'h7EA2: s = "hong";   16'h7EFF: s = "lv";
      16'h84DD: s = "lan";    16'h9EC4: s = "huang";  16'h9ED1: s = "hei";
      16'h7D2B: s = "zi";     16'h7070: s = "hui";    16'h91D1: s = "jin";
      16'h94F6: s = "yin";    16'h4ECA: s = "jin";    16'h6628: s = "zuo";
      16'h5E74: s = "nian";   16'h6708: s = "yue";    16'h65E5: s = "ri";
      16'h65F6: s = "shi";    16'h5206: s = "fen";    16'h79D2: s = "miao";
      16'h65E9: s = "zao";    16'h665A: s = "wan";    16'h5348: s = "wu";
      16'h73B0: s = "xian";   16'h5DF2: s = "yi";     16'h6B63: s = "zheng";
      16'h521A: s = "gang";   16'h624D: s = "cai";    16'h4E4B: s = "zhi";
      16'h4E2D: s = "zhong";  16'h91CC: s = "li";     16'h5916: s = "wai";
      16'h65C1: s = "pang";   16'h8FB9: s = "bian";   16'h95F4: s = "jian";
      16'h9762: s = "mian";   16'h4E1C: s = "dong";   16'h897F: s = "xi";
      16'h5357: s = "nan";    16'h5317: s = "bei";    16'h732B: s = "mao";
      16'h72D7: s = "gou";    16'h9E1F: s = "niao";   16'h9C7C: s = "yu";
      16'h9A6C: s = "ma";     16'h5427: s = "ba";     16'h5417: s = "ma";
      16'h5462: s = "ne";     16'h554A: s = "a";      16'h54E6: s = "o";
      16'h55EF: s = "en";     16'h548C: s = "he";     16'h6216: s = "huo";
      16'h4F46: s = "dan";    16'h56E0: s = "yin";    16'h4E3A: s = "wei";
      16'h6240: s = "suo";    16'h4EE5: s = "yi";     16'h53EF: s = "ke";
      16'h5982: s = "ru";     16'h679C: s = "guo";    16'h867D: s = "sui";
      16'h7136: s = "ran";    16'h6BD4: s = "bi";     16'h4E0E: s = "yu";
      16'h751F: s = "sheng";  16'h6B7B: s = "si";     16'h75C5: s = "bing";
      16'h8001: s = "lao";    16'h7231: s = "ai";     16'h6068: s = "hen";
      16'h559C: s = "xi";     16'h6012: s = "nu";     16'h54C0: s = "ai";
      16'h4E50: s = "le";     16'h7B11: s = "xiao";   16'h54ED: s = "ku";
      16'h5FD9: s = "mang";   16'h95F2: s = "xian";   16'h7D2F: s = "lei";
      16'h56F0: s = "kun";    16'h997F: s = "e";      16'h6E34: s = "ke";
      16'h75DB: s = "tong";   16'h75D2: s = "yang";   16'h6B22: s = "huan";
      16'h8FCE: s = "ying";   16'h8C22: s = "xie";    16'h8BF7: s = "qing";
      16'h5E2E: s = "bang";   16'h52A9: s = "zhu";    16'h9700: s = "xu";
      16'h6C42: s = "qiu";    16'h627E: s = "zhao";   16'h67E5: s = "cha";
      16'h641C: s = "sou";    16'h9001: s = "song";   16'h53D6: s = "qu";
      16'h63A5: s = "jie";    16'h53D1: s = "fa";     16'h6536: s = "shou";
      16'h8BFB: s = "du";     16'h5199: s = "xie";    16'h7B97: s = "suan";
      16'h6570: s = "shu";    16'h804A: s = "liao";   16'h8BB2: s = "jiang";
      16'h4ECB: s = "jie";    16'h7ECD: s = "shao";   16'h5B89: s = "an";
      16'h6559: s = "jiao";   16'h5B66: s = "xue";    16'h7EC3: s = "lian";
      16'h8BD5: s = "shi";    16'h6D4B: s = "ce";     16'h590D: s = "fu";
      16'h64AD: s = "bo";     16'h5531: s = "chang";  16'h8DF3: s = "tiao";
      16'h821E: s = "wu";     16'h6309: s = "an";     16'h7167: s = "zhao";
      16'h53CD: s = "fan";    16'h968F: s = "sui";    16'h4FBF: s = "bian";
      16'h633A: s = "ting";   16'h68D2: s = "bang";   16'h8BEF: s = "wu";
      16'h80AF: s = "ken";    16'h5B9A: s = "ding";   16'h5426: s = "fou";
      16'h8BA4: s = "ren";    16'h8BE5: s = "gai";    16'h6BCF: s = "mei";
      16'h4E9B: s = "xie";    16'h79CD: s = "zhong";  16'h6837: s = "yang";
      16'h4EF6: s = "jian";   16'h4E2A: s = "ge";     16'h53EA: s = "zhi";
      16'h53CC: s = "shuang"; 16'h672C: s = "ben";    16'h6761: s = "tiao";
      16'h5F20: s = "zhang";  16'h6B21: s = "ci";     16'h904D: s = "bian";
      16'h70B9: s = "dian";   16'h58F0: s = "sheng";  16'h97F3: s = "yin";
      16'h8272: s = "se";     16'h5473: s = "wei";    16'h6C14: s = "qi";
      16'h611F: s = "gan";    16'h89C9: s = "jue";    16'h601D: s = "si";
      16'h610F: s = "yi";     16'h60C5: s = "qing";   16'h7406: s = "li";
      16'h6CD5: s = "fa";     16'h540D: s = "ming";   16'h5B57: s = "zi";
      16'h59D3: s = "xing";   16'h53F7: s = "hao";    16'h7801: s = "ma";
      16'h7F51: s = "wang";   16'h5740: s = "zhi";    16'h56FE: s = "tu";
      16'h7247: s = "pian";   16'h89C6: s = "shi";    16'h9891: s = "pin";
      16'h6587: s = "wen";    16'h8BED: s = "yu";     16'h8A00: s = "yan";
      16'h82F1: s = "ying";   16'h7F8E: s = "mei";    16'h56FD: s = "guo";
      16'h4EAC: s = "jing";   16'h6D77: s = "hai";    16'h5E7F: s = "guang";
      16'h676D: s = "hang";   16'h82CF: s = "su";     16'h5DDE: s = "zhou";
      16'h5DDD: s = "chuan";  16'h6E56: s = "hu";     16'h5C71: s = "shan";
      16'h6CB3: s = "he";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [SylLenW-1:0] syl_len(syl_t s);
    logic [SylLenW-1:0] n;
    n = '0;
    for (int k = 0; k < SylBytes; k++) begin
      if (s[8*k +: 8] != 8'h00) n = SylLenW'(k + 1);
    end
    return n;
  endfunction

endpackage

[hw/rtl/hpkm_hit.sv]
// Keyword compare against the history after each of the newly pushed bytes.
module hpkm_hit import hpkm_pkg::*; #(
  parameter int MaxKeyword = MaxKeywordDef,
  parameter int FillW      = $clog2(MaxKeyword + 1)
) (
  input  byte_t             ext_i [MaxKeyword+MaxPush],
  input  byte_t             kw_i  [KwBytes],
  input  logic [KlenW-1:0]  klen_i,
  input  logic [FillW-1:0]  fill_i,
  input  logic [PushW-1:0]  npush_i,
  output logic              hit_o
);

  localparam int SumW = FillW + PushW;
  localparam int ExtN = MaxKeyword + MaxPush;

  always_comb begin
    logic [SumW-1:0] fj;
    logic            ok;
    int              idx;
    hit_o = 1'b0;
    // d counts pushes still to come after the compared one
    for (int d = 0; d < MaxPush; d++) begin
      fj = SumW'(fill_i) + SumW'(npush_i) - SumW'(d);
      if (fj > SumW'(MaxKeyword)) fj = SumW'(MaxKeyword);
      ok = (PushW'(d) < npush_i) && (klen_i != '0) &&
           (SumW'(klen_i) <= SumW'(MaxKeyword)) && (fj >= SumW'(klen_i));
      for (int i = 0; i < MaxKeyword; i++) begin
        idx = int'(klen_i) - 1 - i + d;
        if (KlenW'(i) < klen_i && idx >= 0 && idx < ExtN) begin
          if (kw_i[i] != ext_i[idx]) ok = 1'b0;
        end
      end
      if (ok) hit_o = 1'b1;
    end
  end

endmodule

[hw/rtl/hanzi_pinyin_keyword_matcher.sv]
// Top level: streaming hanzi-to-pinyin keyword matcher.
//
// Input channel (in_valid_i/in_ready_o): one text byte per beat, end_of_text_i
// set on the last byte of a text. Output channel (out_valid_o/out_ready_i):
// one beat per text carrying keyword_found_o.
// Each byte is decoded, looked up in the ROM and compared against the keyword
// in the cycle it is accepted; one byte per cycle sustained while in_ready_o
// is high. The result of a text shows on the output in the cycle after its
// last byte is accepted. The ROM lookup is combinational; it and the seven
// parallel keyword compares feed the history register.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i); it
// is to be written by the user only while the block is idle, which the block
// does not enforce. Unknown indexes are ignored. Reset clears the window,
// history fill, flags and registers; the block is ready once reset is released.
// A stalled output holds its beat; the input keeps accepting until a second
// result would be due: in_ready_o drops only while a result waits unaccepted
// and the offered byte ends a text.
module hanzi_pinyin_keyword_matcher import hpkm_pkg::*; #(
  parameter int MaxKeyword = MaxKeywordDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_text_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                keyword_found_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int FillW = $clog2(MaxKeyword + 1);
  localparam int ExtN  = MaxKeyword + MaxPush;
  localparam int SumW  = FillW + PushW;

  byte_t              pend_q [2];
  byte_t              pend_d [2];
  logic [1:0]         pcnt_q, pcnt_d;
  byte_t              hist_q [MaxKeyword];
  byte_t              hist_d [MaxKeyword];
  logic [FillW-1:0]   fill_q, fill_d;
  logic               first_q, first_d;
  logic               hit_q, hit_d;
  logic [KlenW-1:0]   klen_q;
  logic [CfgDataW-1:0] kw_q [KwRegs];
  logic               out_valid_q, out_valid_d;
  logic               found_q, found_d;

  logic               accept;
  logic               utf_ok, rom_hit, new_hit;
  logic [15:0]        cp;
  syl_t               syl;
  logic [SylLenW-1:0] slen;
  logic [PushW-1:0]   npush;
  byte_t              push [MaxPush];
  byte_t              ext  [ExtN];
  byte_t              kw   [KwBytes];
  logic [SumW-1:0]    fsum;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i || !end_of_text_i;

  assign utf_ok = (pend_q[0][7:4] == 4'hE) && (pend_q[1][7:6] == 2'b10) &&
                  (text_byte_i[7:6] == 2'b10);
  assign cp      = {pend_q[0][3:0], pend_q[1][5:0], text_byte_i[5:0]};
  assign syl     = rom_syl(cp);
  assign slen    = syl_len(syl);
  assign rom_hit = (pcnt_q == 2'd2) && utf_ok && (syl != '0);
  assign npush   = PushW'(slen) + PushW'(!first_q);

  for (genvar g = 0; g < KwBytes; g++) begin : g_kw
    assign kw[g] = kw_q[g/8][8*(g%8) +: 8];
  end

  // Bytes pushed in order: optional space, then the syllable letters.
  always_comb begin
    int c;
    for (int k = 0; k < MaxPush; k++) begin
      c = first_q ? k : k - 1;
      if (c < 0) push[k] = SpaceChar;
      else if (c < int'(slen)) push[k] = syl[8*(int'(slen) - 1 - c) +: 8];
      else push[k] = 8'h00;
    end
  end

  // History after all pushes, newest first.
  always_comb begin
    int j;
    for (int m = 0; m < ExtN; m++) begin
      j = m - int'(npush);
      if (m < int'(npush)) ext[m] = push[int'(npush) - 1 - m];
      else if (j < MaxKeyword) ext[m] = hist_q[j];
      else ext[m] = 8'h00;
    end
  end

  hpkm_hit #(
    .MaxKeyword (MaxKeyword),
    .FillW      (FillW)
  ) u_hit (
    .ext_i   (ext),
    .kw_i    (kw),
    .klen_i  (klen_q),
    .fill_i  (fill_q),
    .npush_i (npush),
    .hit_o   (new_hit)
  );

  always_comb begin
    pend_d      = pend_q;
    pcnt_d      = pcnt_q;
    hist_d      = hist_q;
    fill_d      = fill_q;
    first_d     = first_q;
    hit_d       = hit_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    fsum        = SumW'(fill_q) + SumW'(npush);
    if (accept) begin
      if (pcnt_q != 2'd2) begin
        pend_d[pcnt_q[0]] = text_byte_i;
        pcnt_d            = pcnt_q + 2'd1;
      end else if (rom_hit) begin
        for (int m = 0; m < MaxKeyword; m++) hist_d[m] = ext[m];
        fill_d  = (fsum > SumW'(MaxKeyword)) ? FillW'(MaxKeyword) : FillW'(fsum);
        hit_d   = hit_q || new_hit;
        first_d = 1'b0;
        pcnt_d  = 2'd0;
      end else begin
        pend_d[0] = pend_q[1];
        pend_d[1] = text_byte_i;
      end
      if (end_of_text_i) begin
        found_d     = (klen_q == '0) || hit_d;
        out_valid_d = 1'b1;
        pcnt_d      = 2'd0;
        fill_d      = '0;
        first_d     = 1'b1;
        hit_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q      <= '0;
      fill_q      <= '0;
      first_q     <= 1'b1;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      klen_q      <= '0;
      for (int r = 0; r < KwRegs; r++) kw_q[r] <= '0;
    end else begin
      pcnt_q      <= pcnt_d;
      fill_q      <= fill_d;
      first_q     <= first_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegKeywordLength: klen_q  <= cfg_wdata_i[KlenW-1:0];
          RegKeyword0:      kw_q[0] <= cfg_wdata_i;
          RegKeyword1:      kw_q[1] <= cfg_wdata_i;
          RegKeyword2:      kw_q[2] <= cfg_wdata_i;
          RegKeyword3:      kw_q[3] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    hist_q  <= hist_d;
    found_q <= found_d;
  end

  assign out_valid_o     = out_valid_q;
  assign keyword_found_o = found_q;

endmodule

[hw/rtl/hpkm_checker.sv]
// Port-level checker for the pinyin keyword matcher, bound to the top level.
`include "hanzi_pinyin_keyword_matcher_assert.svh"

module hpkm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic end_of_text_i,
  input logic out_valid_o,
  input logic out_ready_i
);

  `HPKM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped")
  `HPKM_ASSERT_IMP(a_stall_blocks, out_valid_o && !out_ready_i && end_of_text_i, !in_ready_o, "input open on stall")
  `HPKM_ASSERT_IMP(a_ready_free, !out_valid_o, in_ready_o, "input blocked while output empty")
  `HPKM_ASSERT_NXT(a_eot_result, in_valid_i && in_ready_o && end_of_text_i, out_valid_o, "no result")

endmodule

bind hanzi_pinyin_keyword_matcher hpkm_checker u_hpkm_checker (.*);

[tb/sv/hanzi_pinyin_keyword_matcher_tb.sv]
// Testbench: drives UTF-8 texts into the pinyin keyword matcher and checks each found flag.
module hanzi_pinyin_keyword_matcher_tb;
  import hpkm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;

  typedef struct packed {
    byte_t tb_byte;
    logic  eot;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  byte_t text_byte = '0;
  logic end_of_text = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic keyword_found;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  hanzi_pinyin_keyword_matcher u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .text_byte_i(text_byte), .end_of_text_i(end_of_text),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .keyword_found_o(keyword_found),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hanzi to pinyin table, built independently of the design
  string pinyin_of[int unsigned];
  int unsigned hanzi_cps[$];

  text_beat_t pending_beats[$];
  bit found_q[$];
  bit idle_on = 1'b1;
  int hold_req = 0;
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int cycles = 0;

  // predictor state
  logic [5:0] kw_len = '0;
  logic [63:0] kw_regs [KwRegs];
  byte_t win [2];
  int win_cnt;
  byte_t hist [MaxKeywordDef];
  int hist_fill;
  bit first_syl;
  bit hit;

  task automatic rom_add(int unsigned cp, string s);
    pinyin_of[cp] = s;
    hanzi_cps.push_back(cp);
  endtask

  task automatic rom_fill();
    rom_add('h4F60,"ni"); rom_add('h597D,"hao"); rom_add('h5C0F,"xiao"); rom_add('h5343,"qian");
    rom_add('h7AD9,"zhan"); rom_add('h8D77,"qi"); rom_add('h6765,"lai"); rom_add('h8BF4,"shuo");
    rom_add('h8BDD,"hua"); rom_add('h6253,"da"); rom_add('h5F00,"kai"); rom_add('h5173,"guan");
    rom_add('h505C,"ting"); rom_add('h8D70,"zou"); rom_add('h8DD1,"pao"); rom_add('h524D,"qian");
    rom_add('h540E,"hou"); rom_add('h5DE6,"zuo"); rom_add('h53F3,"you"); rom_add('h4E0A,"shang");
    rom_add('h4E0B,"xia"); rom_add('h56DE,"hui"); rom_add('h53BB,"qu"); rom_add('h8F6C,"zhuan");
    rom_add('h662F,"shi"); rom_add('h6709,"you"); rom_add('h4E0D,"bu"); rom_add('h5728,"zai");
    rom_add('h4E86,"le"); rom_add('h4F1A,"hui"); rom_add('h80FD,"neng"); rom_add('h8981,"yao");
    rom_add('h60F3,"xiang"); rom_add('h770B,"kan"); rom_add('h542C,"ting"); rom_add('h5403,"chi");
    rom_add('h559D,"he"); rom_add('h505A,"zuo"); rom_add('h8BA9,"rang"); rom_add('h7ED9,"gei");
    rom_add('h62FF,"na"); rom_add('h653E,"fang"); rom_add('h7B49,"deng"); rom_add('h5E26,"dai");
    rom_add('h95EE,"wen"); rom_add('h7B54,"da"); rom_add('h544A,"gao"); rom_add('h8BC9,"su");
    rom_add('h77E5,"zhi"); rom_add('h9053,"dao"); rom_add('h660E,"ming"); rom_add('h767D,"bai");
    rom_add('h61C2,"dong"); rom_add('h8BB0,"ji"); rom_add('h6211,"wo"); rom_add('h4ED6,"ta");
    rom_add('h5979,"ta"); rom_add('h5B83,"ta"); rom_add('h4EEC,"men"); rom_add('h8FD9,"zhe");
    rom_add('h90A3,"na"); rom_add('h54EA,"na"); rom_add('h4EC0,"shen"); rom_add('h4E48,"me");
    rom_add('h8C01,"shui"); rom_add('h4EBA,"ren"); rom_add('h5BB6,"jia"); rom_add('h670B,"peng");
    rom_add('h53CB,"you"); rom_add('h673A,"ji"); rom_add('h5668,"qi"); rom_add('h5929,"tian");
    rom_add('h5730,"di"); rom_add('h6C34,"shui"); rom_add('h706B,"huo"); rom_add('h98CE,"feng");
    rom_add('h96E8,"yu"); rom_add('h4E91,"yun"); rom_add('h82B1,"hua"); rom_add('h4E66,"shu");
    rom_add('h7535,"dian"); rom_add('h95E8,"men"); rom_add('h7A97,"chuang"); rom_add('h8F66,"che");
    rom_add('h623F,"fang"); rom_add('h684C,"zhuo"); rom_add('h6905,"yi"); rom_add('h996D,"fan");
    rom_add('h83DC,"cai"); rom_add('h8336,"cha"); rom_add('h9152,"jiu"); rom_add('h624B,"shou");
    rom_add('h811A,"jiao"); rom_add('h5934,"tou"); rom_add('h773C,"yan"); rom_add('h8033,"er");
    rom_add('h53E3,"kou"); rom_add('h9F3B,"bi"); rom_add('h5FC3,"xin"); rom_add('h5927,"da");
    rom_add('h591A,"duo"); rom_add('h5C11,"shao"); rom_add('h9AD8,"gao"); rom_add('h4F4E,"di");
    rom_add('h957F,"chang"); rom_add('h77ED,"duan"); rom_add('h5FEB,"kuai"); rom_add('h6162,"man");
    rom_add('h65B0,"xin"); rom_add('h65E7,"jiu"); rom_add('h574F,"huai"); rom_add('h5BF9,"dui");
    rom_add('h9519,"cuo"); rom_add('h771F,"zhen"); rom_add('h5047,"jia"); rom_add('h70ED,"re");
    rom_add('h51B7,"leng"); rom_add('h5E72,"gan"); rom_add('h6E7F,"shi"); rom_add('h4EAE,"liang");
    rom_add('h6697,"an"); rom_add('h8F7B,"qing"); rom_add('h91CD,"zhong"); rom_add('h8FDC,"yuan");
    rom_add('h8FD1,"jin"); rom_add('h6DF1,"shen"); rom_add('h6D45,"qian"); rom_add('h5F88,"hen");
    rom_add('h592A,"tai"); rom_add('h6700,"zui"); rom_add('h66F4,"geng"); rom_add('h975E,"fei");
    rom_add('h5E38,"chang"); rom_add('h90FD,"dou"); rom_add('h4E5F,"ye"); rom_add('h8FD8,"hai");
    rom_add('h5C31,"jiu"); rom_add('h4E00,"yi"); rom_add('h4E8C,"er"); rom_add('h4E09,"san");
    rom_add('h56DB,"si"); rom_add('h4E94,"wu"); rom_add('h516D,"liu"); rom_add('h4E03,"qi");
    rom_add('h516B,"ba"); rom_add('h4E5D,"jiu"); rom_add('h5341,"shi"); rom_add('h767E,"bai");
    rom_add('h4E07,"wan"); rom_add('h4EBF,"yi"); rom_add('h96F6,"ling"); rom_add('h7EA2,"hong");
    rom_add('h7EFF,"lv"); rom_add('h84DD,"lan"); rom_add('h9EC4,"huang"); rom_add('h9ED1,"hei");
    rom_add('h7D2B,"zi"); rom_add('h7070,"hui"); rom_add('h91D1,"jin"); rom_add('h94F6,"yin");
    rom_add('h4ECA,"jin"); rom_add('h6628,"zuo"); rom_add('h5E74,"nian"); rom_add('h6708,"yue");
    rom_add('h65E5,"ri"); rom_add('h65F6,"shi"); rom_add('h5206,"fen"); rom_add('h79D2,"miao");
    rom_add('h65E9,"zao"); rom_add('h665A,"wan"); rom_add('h5348,"wu"); rom_add('h73B0,"xian");
    rom_add('h5DF2,"yi"); rom_add('h6B63,"zheng"); rom_add('h521A,"gang"); rom_add('h624D,"cai");
    rom_add('h4E4B,"zhi"); rom_add('h4E2D,"zhong"); rom_add('h91CC,"li"); rom_add('h5916,"wai");
    rom_add('h65C1,"pang"); rom_add('h8FB9,"bian"); rom_add('h95F4,"jian"); rom_add('h9762,"mian");
    rom_add('h4E1C,"dong"); rom_add('h897F,"xi"); rom_add('h5357,"nan"); rom_add('h5317,"bei");
    rom_add('h732B,"mao"); rom_add('h72D7,"gou"); rom_add('h9E1F,"niao"); rom_add('h9C7C,"yu");
    rom_add('h9A6C,"ma"); rom_add('h5427,"ba"); rom_add('h5417,"ma"); rom_add('h5462,"ne");
    rom_add('h554A,"a"); rom_add('h54E6,"o"); rom_add('h55EF,"en"); rom_add('h548C,"he");
    rom_add('h6216,"huo"); rom_add('h4F46,"dan"); rom_add('h56E0,"yin"); rom_add('h4E3A,"wei");
    rom_add('h6240,"suo"); rom_add('h4EE5,"yi"); rom_add('h53EF,"ke"); rom_add('h5982,"ru");
    rom_add('h679C,"guo"); rom_add('h867D,"sui"); rom_add('h7136,"ran"); rom_add('h6BD4,"bi");
    rom_add('h4E0E,"yu"); rom_add('h751F,"sheng"); rom_add('h6B7B,"si"); rom_add('h75C5,"bing");
    rom_add('h8001,"lao"); rom_add('h7231,"ai"); rom_add('h6068,"hen"); rom_add('h559C,"xi");
    rom_add('h6012,"nu"); rom_add('h54C0,"ai"); rom_add('h4E50,"le"); rom_add('h7B11,"xiao");
    rom_add('h54ED,"ku"); rom_add('h5FD9,"mang"); rom_add('h95F2,"xian"); rom_add('h7D2F,"lei");
    rom_add('h56F0,"kun"); rom_add('h997F,"e"); rom_add('h6E34,"ke"); rom_add('h75DB,"tong");
    rom_add('h75D2,"yang"); rom_add('h6B22,"huan"); rom_add('h8FCE,"ying"); rom_add('h8C22,"xie");
    rom_add('h8BF7,"qing"); rom_add('h5E2E,"bang"); rom_add('h52A9,"zhu"); rom_add('h9700,"xu");
    rom_add('h6C42,"qiu"); rom_add('h627E,"zhao"); rom_add('h67E5,"cha"); rom_add('h641C,"sou");
    rom_add('h9001,"song"); rom_add('h53D6,"qu"); rom_add('h63A5,"jie"); rom_add('h53D1,"fa");
    rom_add('h6536,"shou"); rom_add('h8BFB,"du"); rom_add('h5199,"xie"); rom_add('h7B97,"suan");
    rom_add('h6570,"shu"); rom_add('h804A,"liao"); rom_add('h8BB2,"jiang"); rom_add('h4ECB,"jie");
    rom_add('h7ECD,"shao"); rom_add('h5B89,"an"); rom_add('h6559,"jiao"); rom_add('h5B66,"xue");
    rom_add('h7EC3,"lian"); rom_add('h8BD5,"shi"); rom_add('h6D4B,"ce"); rom_add('h590D,"fu");
    rom_add('h64AD,"bo"); rom_add('h5531,"chang"); rom_add('h8DF3,"tiao"); rom_add('h821E,"wu");
    rom_add('h6309,"an"); rom_add('h7167,"zhao"); rom_add('h53CD,"fan"); rom_add('h968F,"sui");
    rom_add('h4FBF,"bian"); rom_add('h633A,"ting"); rom_add('h68D2,"bang"); rom_add('h8BEF,"wu");
    rom_add('h80AF,"ken"); rom_add('h5B9A,"ding"); rom_add('h5426,"fou"); rom_add('h8BA4,"ren");
    rom_add('h8BE5,"gai"); rom_add('h6BCF,"mei"); rom_add('h4E9B,"xie"); rom_add('h79CD,"zhong");
    rom_add('h6837,"yang"); rom_add('h4EF6,"jian"); rom_add('h4E2A,"ge"); rom_add('h53EA,"zhi");
    rom_add('h53CC,"shuang"); rom_add('h672C,"ben"); rom_add('h6761,"tiao"); rom_add('h5F20,"zhang");
    rom_add('h6B21,"ci"); rom_add('h904D,"bian"); rom_add('h70B9,"dian"); rom_add('h58F0,"sheng");
    rom_add('h97F3,"yin"); rom_add('h8272,"se"); rom_add('h5473,"wei"); rom_add('h6C14,"qi");
    rom_add('h611F,"gan"); rom_add('h89C9,"jue"); rom_add('h601D,"si"); rom_add('h610F,"yi");
    rom_add('h60C5,"qing"); rom_add('h7406,"li"); rom_add('h6CD5,"fa"); rom_add('h540D,"ming");
    rom_add('h5B57,"zi"); rom_add('h59D3,"xing"); rom_add('h53F7,"hao"); rom_add('h7801,"ma");
    rom_add('h7F51,"wang"); rom_add('h5740,"zhi"); rom_add('h56FE,"tu"); rom_add('h7247,"pian");
    rom_add('h89C6,"shi"); rom_add('h9891,"pin"); rom_add('h6587,"wen"); rom_add('h8BED,"yu");
    rom_add('h8A00,"yan"); rom_add('h82F1,"ying"); rom_add('h7F8E,"mei"); rom_add('h56FD,"guo");
    rom_add('h4EAC,"jing"); rom_add('h6D77,"hai"); rom_add('h5E7F,"guang"); rom_add('h676D,"hang");
    rom_add('h82CF,"su"); rom_add('h5DDE,"zhou"); rom_add('h5DDD,"chuan"); rom_add('h6E56,"hu");
    rom_add('h5C71,"shan"); rom_add('h6CB3,"he");
  endtask

  task automatic clear_text();
    win_cnt = 0;
    win[0] = '0;
    win[1] = '0;
    for (int i = 0; i < MaxKeywordDef; i++) hist[i] = '0;
    hist_fill = 0;
    first_syl = 1'b1;
    hit = 1'b0;
  endtask

  task automatic history_push(byte_t b);
    bit eq;
    int len;
    eq = 1'b1;
    len = kw_len;
    for (int i = MaxKeywordDef - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = b;
    if (hist_fill < MaxKeywordDef) hist_fill++;
    if (len == 0 || len > MaxKeywordDef || hist_fill < len) return;
    for (int i = 0; i < len; i++)
      if (kw_regs[i/8][(i%8)*8 +: 8] != hist[len-1-i]) eq = 1'b0;
    if (eq) hit = 1'b1;
  endtask

  task automatic predict_found(byte_t b, logic eot);
    int unsigned cp;
    bit well_formed;
    string syl;
    if (win_cnt < 2) begin
      win[win_cnt] = b;
      win_cnt++;
    end else begin
      well_formed = win[0][7:4] == 4'hE && win[1][7:6] == 2'b10 && b[7:6] == 2'b10;
      cp = {win[0][3:0], win[1][5:0], b[5:0]};
      if (well_formed && pinyin_of.exists(cp)) begin
        syl = pinyin_of[cp];
        if (!first_syl) history_push(SpaceChar);
        for (int k = 0; k < syl.len(); k++) history_push(byte_t'(syl[k]));
        first_syl = 1'b0;
        win_cnt = 0;
      end else begin
        win[0] = win[1];
        win[1] = b;
      end
    end
    if (eot) begin
      found_q.push_back(kw_len == 0 || hit);
      clear_text();
    end
  endtask

  task automatic report(string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // sender
  int tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    text_beat_t nb;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        nb = pending_beats.pop_front();
        in_valid <= 1'b1;
        text_byte <= nb.tb_byte;
        end_of_text <= nb.eot;
        if (idle_on && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with random short gaps and one long hold-off
  int rx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_req--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 9);
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    bit exp_found;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        beats_sent++;
        predict_found(text_byte, end_of_text);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (found_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          exp_found = found_q.pop_front();
          if (keyword_found !== exp_found)
            report($sformatf("keyword_found %b, expected %b", keyword_found, exp_found));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic cfg_write(cfg_reg_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == RegKeywordLength) kw_len = data[5:0];
    else kw_regs[idx - 1] = data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_write_raw(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid || found_q.size() > 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send(byte_t b, logic eot);
    pending_beats.push_back('{tb_byte: b, eot: eot});
  endtask

  task automatic send_hanzi(int unsigned cp, int nbytes, logic eot);
    byte_t enc [3];
    enc[0] = byte_t'(8'hE0 | (cp >> 12));
    enc[1] = byte_t'(8'h80 | ((cp >> 6) & 'h3F));
    enc[2] = byte_t'(8'h80 | (cp & 'h3F));
    for (int i = 0; i < nbytes; i++) send(enc[i], eot && i == nbytes - 1);
  endtask

  task automatic set_keyword(string kw, int len);
    logic [63:0] r [KwRegs];
    for (int i = 0; i < KwRegs; i++) r[i] = '0;
    for (int i = 0; i < kw.len() && i < KwBytes; i++) r[i/8][(i%8)*8 +: 8] = kw[i];
    cfg_write(RegKeywordLength, 64'(len));
    for (int i = 0; i < KwRegs; i++) cfg_write(cfg_reg_e'(RegKeyword0 + i), r[i]);
    settings_used++;
  endtask

  function automatic string render(int unsigned cps[$]);
    string s;
    s = "";
    foreach (cps[i]) s = (i == 0) ? pinyin_of[cps[i]] : {s, " ", pinyin_of[cps[i]]};
    return s;
  endfunction

  function automatic int unsigned any_hanzi();
    return hanzi_cps[$urandom_range(0, hanzi_cps.size() - 1)];
  endfunction

  // a random text; the keyword's hanzi run is spliced in sometimes
  task automatic send_text(int unsigned kw_cps[$], output int n);
    int units;
    int pick;
    int splice_at;
    int part;
    units = $urandom_range(1, 10);
    splice_at = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, units - 1);
    n = 0;
    for (int u = 0; u < units; u++) begin
      if (u == splice_at) begin
        foreach (kw_cps[i]) send_hanzi(kw_cps[i], 3, 1'b0);
        n += 3 * kw_cps.size();
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_hanzi(any_hanzi(), 3, 1'b0);
        n += 3;
      end else if (pick == 7) begin
        send(byte_t'($urandom_range(0, 255)), 1'b0);
        n++;
      end else if (pick == 8) begin
        send(byte_t'($urandom_range(8'h20, 8'h7E)), 1'b0);
        n++;
      end else begin
        part = $urandom_range(1, 2);
        send_hanzi(any_hanzi(), part, 1'b0);
        n += part;
      end
    end
    // last byte: random, or the tail byte of a hanzi
    if ($urandom_range(0, 1) == 0) begin
      send(byte_t'($urandom_range(0, 255)), 1'b1);
      n += 1;
    end else begin
      send_hanzi(any_hanzi(), 3, 1'b1);
      n += 3;
    end
  endtask

  initial begin
    int unsigned run[$];
    int unsigned none[$];
    string rend;
    int lens [10];
    int len;
    int start;
    int sent;
    int n;
    logic [63:0] rv;
    lens = '{1, 32, 5, 0, 33, 63, -1, 12, 32, -1};
    for (int i = 0; i < KwRegs; i++) kw_regs[i] = '0;
    rom_fill();
    clear_text();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero keyword length: every text is a hit
    send(8'h00, 1'b1);
    send_hanzi('h4F60, 3, 1'b1);
    send_hanzi('h597D, 2, 1'b1);
    send(8'hFF, 1'b0);
    send(8'hFF, 1'b1);
    wait_idle();

    set_keyword("ni hao", 6);
    send_hanzi('h4F60, 3, 1'b0);
    send_hanzi('h597D, 3, 1'b1);
    send(8'h41, 1'b0);
    send_hanzi('h4F60, 3, 1'b0);
    send(8'hE5, 1'b0);
    send_hanzi('h597D, 3, 1'b1);
    wait_idle();
    // writes to unused indexes change nothing
    cfg_write_raw(3'd5, '1);
    cfg_write_raw(3'd6, '1);
    cfg_write_raw(3'd7, 64'h0);
    send_hanzi('h4F60, 3, 1'b0);
    send_hanzi('h597D, 3, 1'b1);
    wait_idle();

    set_keyword("hao", 33);
    send_hanzi('h597D, 3, 1'b1);
    wait_idle();
    cfg_write(RegKeyword0, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(RegKeywordLength, 64'd1);
    send(8'hFF, 1'b0);
    send_hanzi('h554A, 3, 1'b1);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      if (p == 9) idle_on = 1'b0;
      run.delete();
      if (lens[p] < 0 || lens[p] > MaxKeywordDef) begin
        len = (lens[p] < 0) ? $urandom_range(0, 63) : lens[p];
        cfg_write(RegKeywordLength, 64'(len));
        for (int i = 0; i < KwRegs; i++) begin
          rv = {$urandom, $urandom};
          cfg_write(cfg_reg_e'(RegKeyword0 + i), rv);
        end
        settings_used++;
      end else begin
        do begin
          run.push_back(any_hanzi());
          rend = render(run);
        end while (rend.len() < lens[p] + 2);
        start = $urandom_range(0, rend.len() - lens[p]);
        set_keyword(rend.substr(start, start + lens[p] - 1), lens[p]);
      end
      if (p == 3) begin
        @(negedge clk_i);
        hold_req = 300;
      end
      sent = 0;
      while (sent < 80) begin
        send_text(($urandom_range(0, 3) == 0) ? none : run, n);
        sent += n;
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d text bytes sent, %0d found flags checked, %0d keyword settings",
             beats_sent, results_seen, settings_used);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
